// ----- design/utf16u8_pkg.sv -----
// Package with types, constants and the UTF-8 encoder shared by the transcoder.
`timescale 1ns / 1ps
package utf16u8_pkg;

  localparam int unsigned IdxW      = 6;
  localparam int unsigned MaxBytes  = 7;
  localparam int unsigned CntW      = 3;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [7:0]  CapReset  = 8'd72;
  localparam logic        RegOutCap = 1'b0;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] Replace   = 21'h00FFFD;
  localparam logic [20:0] SuppBase  = 21'h010000;
  localparam logic [20:0] Max1Byte  = 21'h00007F;
  localparam logic [20:0] Max2Byte  = 21'h0007FF;
  localparam logic [20:0] Max3Byte  = 21'h00FFFF;
  localparam logic [7:0]  Lead2     = 8'hC0;
  localparam logic [7:0]  Lead3     = 8'hE0;
  localparam logic [7:0]  Lead4     = 8'hF0;
  localparam logic [7:0]  ContMark  = 8'h80;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [CntW-1:0] cnt;
  } enc_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     term;
  } job_t;

  function automatic enc_t encode(logic [20:0] cp);
    enc_t r;
    r = '0;
    if (cp <= Max1Byte) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp <= Max2Byte) begin
      r.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      r.bytes[1] = ContMark | {2'b00, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp <= Max3Byte) begin
      r.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      r.bytes[1] = ContMark | {2'b00, cp[11:6]};
      r.bytes[2] = ContMark | {2'b00, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      r.bytes[1] = ContMark | {2'b00, cp[17:12]};
      r.bytes[2] = ContMark | {2'b00, cp[11:6]};
      r.bytes[3] = ContMark | {2'b00, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

// ----- design/utf16u8_if.sv -----
// Request and result channel interfaces of the transcoder.
`timescale 1ns / 1ps
interface utf16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first_unit;

  modport source (output valid, output code_unit, output first_unit, input ready);
  modport sink (input valid, input code_unit, input first_unit, output ready);
endinterface

interface utf16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic       last;

  modport source (output valid, output out_byte, output is_terminator, output last,
                  input ready);
  modport sink (input valid, input out_byte, input is_terminator, input last,
                output ready);
endinterface

// ----- design/utf16u8_front.sv -----
// Front end: accepts code units, tracks name state and builds byte jobs.
`timescale 1ns / 1ps
module utf16u8_front #(
  parameter int unsigned MAX_UNITS = 36
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  utf16u8_in_if.sink         req_i,
  input  logic [7:0]         cap_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output utf16u8_pkg::job_t  job_o
);
  import utf16u8_pkg::*;

  localparam logic [IdxW-1:0] LastSlot = IdxW'(MAX_UNITS - 1);

  logic [7:0]      used_q, used_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [9:0]      held_q, held_d;
  logic            held_v_q, held_v_d;
  logic            done_q, done_d;

  logic [15:0]     u;
  logic            accept, first, ignore;
  logic [7:0]      used0, used_a;
  logic [IdxW-1:0] idx0;
  logic            held_v0, final_slot;
  logic            is_low, is_high, is_zero, pair, hold_new, term;
  logic            a_en, b_en, a_fit, b_fit;
  logic [20:0]     cp_a, cp_b;
  enc_t            enc_a, enc_b;
  logic [CntW-1:0] n_a, n_b;

  assign req_i.ready = q_ready_i;
  assign accept      = req_i.valid && q_ready_i;
  assign u           = req_i.code_unit;
  assign first       = req_i.first_unit;

  assign used0   = first ? '0 : used_q;
  assign idx0    = first ? '0 : idx_q;
  assign held_v0 = first ? 1'b0 : held_v_q;
  assign ignore  = !first && done_q;

  assign is_low     = (u >= LowFirst) && (u <= LowLast);
  assign is_high    = (u >= HighFirst) && (u <= HighLast);
  assign is_zero    = (u == '0);
  assign final_slot = (idx0 >= LastSlot);

  assign pair     = held_v0 && is_low;
  assign a_en     = held_v0;
  assign cp_a     = pair ? (SuppBase + {1'b0, held_q, u[9:0]}) : Replace;
  assign b_en     = !pair && !is_zero && (!is_high || final_slot);
  assign cp_b     = (is_high || is_low) ? Replace : {5'b00000, u};
  assign term     = final_slot || (is_zero && !pair);
  assign hold_new = !pair && is_high && !final_slot;

  assign enc_a  = encode(cp_a);
  assign enc_b  = encode(cp_b);
  assign a_fit  = a_en && (({1'b0, used0} + {6'b0, enc_a.cnt}) < {1'b0, cap_i});
  assign n_a    = a_fit ? enc_a.cnt : '0;
  assign used_a = used0 + {5'b0, n_a};
  assign b_fit  = b_en && (({1'b0, used_a} + {6'b0, enc_b.cnt}) < {1'b0, cap_i});
  assign n_b    = b_fit ? enc_b.cnt : '0;

  always_comb begin
    logic [CntW-1:0] kk;
    logic [CntW-1:0] dk;
    logic [CntW-1:0] n_ab;
    n_ab       = n_a + n_b;
    job_o.term = term;
    job_o.cnt  = n_ab + {2'b00, term};
    for (int k = 0; k < MaxBytes; k++) begin
      kk = CntW'(k);
      dk = kk - n_a;
      if (kk < n_a) begin
        job_o.bytes[k] = enc_a.bytes[kk[1:0]];
      end else if (kk < n_ab) begin
        job_o.bytes[k] = enc_b.bytes[dk[1:0]];
      end else begin
        job_o.bytes[k] = '0;
      end
    end
  end

  assign push_o = accept && !ignore && (job_o.cnt != '0);

  always_comb begin
    used_d   = used_q;
    idx_d    = idx_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    done_d   = done_q;
    if (accept && !ignore) begin
      used_d   = used_a + {5'b0, n_b};
      held_v_d = hold_new;
      held_d   = hold_new ? u[9:0] : held_q;
      done_d   = term;
      idx_d    = term ? idx0 : idx0 + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      idx_q    <= '0;
      held_q   <= '0;
      held_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      used_q   <= used_d;
      idx_q    <= idx_d;
      held_q   <= held_d;
      held_v_q <= held_v_d;
      done_q   <= done_d;
    end
  end

endmodule

// ----- design/utf16u8_fifo.sv -----
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
module utf16u8_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  utf16u8_pkg::job_t job_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output utf16u8_pkg::job_t head_o
);
  import utf16u8_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/utf16u8_back.sv -----
// Back end: sends the bytes of each queued job one result at a time.
`timescale 1ns / 1ps
module utf16u8_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  utf16u8_pkg::job_t job_i,
  output logic              pop_o,
  utf16u8_out_if.source     rsp_o
);
  import utf16u8_pkg::*;

  logic [CntW-1:0] pos_q, pos_d;
  logic            at_end, take;

  assign at_end = (pos_q == job_i.cnt - 1'b1);
  assign take   = valid_i && rsp_o.ready;
  assign pop_o  = take && at_end;

  assign rsp_o.valid         = valid_i;
  assign rsp_o.out_byte      = job_i.bytes[pos_q];
  assign rsp_o.last          = at_end;
  assign rsp_o.is_terminator = at_end && job_i.term;

  always_comb begin
    pos_d = pos_q;
    if (pop_o) begin
      pos_d = '0;
    end else if (take) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- design/utf16le_to_utf8_name_transcoder_core.sv -----
// Top level of the UTF-16LE to UTF-8 name transcoder.
//
//   Port     Direction  Moves
//   req_i    in         one UTF-16 code unit and its first-unit mark per request
//   rsp_o    out        one UTF-8 byte with terminator and last marks per request
//   APB      in/out     out_capacity register at byte address 0
//
// A code unit is taken whenever the job queue has room.
// The byte serializer sends the result bytes of each job in turn; a unit
// yields zero to seven of them, usually one.
// The two-entry job queue lets requests keep arriving while results stall.
// Reset clears the name state and sets out_capacity to 72.
`timescale 1ns / 1ps
module utf16le_to_utf8_name_transcoder_core #(
  parameter int unsigned MAX_UNITS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf16u8_in_if.sink  req_i,
  utf16u8_out_if.source rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [utf16u8_pkg::PaddrW-1:0] paddr,
  input  logic [utf16u8_pkg::PdataW-1:0] pwdata,
  output logic [utf16u8_pkg::PdataW-1:0] prdata,
  output logic        pready
);
  import utf16u8_pkg::*;

  logic [7:0] cap_q, cap_d;
  logic       cfg_wr;
  logic       push, q_ready, q_valid, pop;
  job_t       job_in, job_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegOutCap);
  assign cap_d  = cfg_wr ? pwdata[7:0] : cap_q;
  assign prdata = (paddr[2] == RegOutCap) ? {{(PdataW - 8){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  utf16u8_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cap_i    (cap_q),
    .q_ready_i(q_ready),
    .push_o   (push),
    .job_o    (job_in)
  );

  utf16u8_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (job_head)
  );

  utf16u8_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .job_i  (job_head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- design/utf16u8_checker.sv -----
// Port-level checks of the transcoder, bound to the top level.
`timescale 1ns / 1ps
module utf16u8_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        is_term_i,
  input logic        last_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic        paddr2_i,
  input logic [7:0]  pwdata_i,
  input logic [7:0]  prdata_i,
  input logic        pready_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_term_i |-> last_i && (out_byte_i == 8'h00))
    else $error("Terminator is not a last zero byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result withdrawn while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && !paddr2_i |=>
      paddr2_i || (prdata_i == $past(pwdata_i)))
    else $error("Capacity readback differs from the value written.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("Configuration port stalled.");

endmodule

bind utf16le_to_utf8_name_transcoder_core utf16u8_port_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .out_byte_i (rsp_o.out_byte),
  .is_term_i  (rsp_o.is_terminator),
  .last_i     (rsp_o.last),
  .psel_i     (psel),
  .penable_i  (penable),
  .pwrite_i   (pwrite),
  .paddr2_i   (paddr[2]),
  .pwdata_i   (pwdata[7:0]),
  .prdata_i   (prdata[7:0]),
  .pready_i   (pready)
);

// ----- tb/utf16u8_checker.sv -----
// Monitor that predicts the transcoder's UTF-8 bytes and compares them with its results.
`timescale 1ns / 1ps
module utf16u8_checker #(
  parameter int unsigned MAX_UNITS = 36
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  utf16u8_in_if                               req_i,
  utf16u8_out_if                              rsp_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic                                pready_i,
  input  logic [utf16u8_pkg::PaddrW-1:0]      paddr_i,
  input  logic [utf16u8_pkg::PdataW-1:0]      pwdata_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import utf16u8_pkg::*;

  localparam logic [PaddrW-1:0] CapAddr = PaddrW'(4 * RegOutCap);
  localparam int unsigned ShownMax = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } utf8_byte_t;

  utf8_byte_t utf8_expect_q[$];
  utf8_byte_t unit_bytes_q[$];

  logic [7:0] capacity_q;
  logic [7:0] used_q;
  logic [5:0] slot_q;
  logic [9:0] held_q;
  logic       held_vld_q;
  logic       done_q;
  int unsigned mismatches;

  task automatic clear_name();
    used_q     = '0;
    slot_q     = '0;
    held_q     = '0;
    held_vld_q = 1'b0;
    done_q     = 1'b0;
  endtask

  task automatic put_nul();
    unit_bytes_q.push_back('{data: 8'h00, term: 1'b1, last: 1'b0});
  endtask

  task automatic put_char(input logic [20:0] cp);
    logic [7:0] enc [4];
    int unsigned cnt;
    enc = '{default: 8'h00};
    if (cp <= Max1Byte) begin
      enc[0] = cp[7:0];
      cnt = 1;
    end else if (cp <= Max2Byte) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      cnt = 2;
    end else if (cp <= Max3Byte) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      cnt = 3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      cnt = 4;
    end
    // The character is dropped whole when it would not leave room for the NUL.
    if (int'(used_q) + int'(cnt) < int'(capacity_q)) begin
      for (int k = 0; k < int'(cnt); k++) begin
        unit_bytes_q.push_back('{data: enc[k], term: 1'b0, last: 1'b0});
      end
      used_q = used_q + 8'(cnt);
    end
  endtask

  task automatic transcode_unit(input logic [15:0] unit, input logic first);
    logic       is_lo;
    logic       is_hi;
    logic       fin;
    logic       paired;
    logic       advance;
    logic [5:0] slot;
    unit_bytes_q.delete();
    is_lo   = (unit >= LowFirst) && (unit <= LowLast);
    is_hi   = (unit >= HighFirst) && (unit <= HighLast);
    paired  = 1'b0;
    advance = 1'b0;
    if (first) begin
      clear_name();
    end
    if (first || !done_q) begin
      slot = slot_q;
      fin  = (int'(slot) >= int'(MAX_UNITS) - 1);
      if (held_vld_q) begin
        held_vld_q = 1'b0;
        if (is_lo) begin
          put_char(SuppBase + 21'({held_q, 10'd0}) + 21'(unit - LowFirst));
          paired = 1'b1;
        end else begin
          put_char(Replace);
        end
      end
      if (paired) begin
        advance = 1'b1;
      end else if (unit == 16'h0000) begin
        put_nul();
        done_q = 1'b1;
      end else if (is_hi) begin
        if (fin) begin
          put_char(Replace);
          put_nul();
          done_q = 1'b1;
        end else begin
          held_q     = unit[9:0];
          held_vld_q = 1'b1;
          slot_q     = slot + 6'd1;
        end
      end else begin
        put_char(is_lo ? Replace : 21'(unit));
        advance = 1'b1;
      end
      if (advance) begin
        if (fin) begin
          put_nul();
          done_q = 1'b1;
        end else begin
          slot_q = slot + 6'd1;
        end
      end
    end
    if (unit_bytes_q.size() > 0) begin
      unit_bytes_q[unit_bytes_q.size() - 1].last = 1'b1;
    end
    foreach (unit_bytes_q[k]) begin
      utf8_expect_q.push_back(unit_bytes_q[k]);
    end
  endtask

  task automatic compare_byte(input utf8_byte_t got);
    utf8_byte_t want;
    if (utf8_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= ShownMax) begin
        $display("unexpected result: byte %02h term %0b last %0b with nothing pending",
                 got.data, got.term, got.last);
      end
    end else begin
      want = utf8_expect_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ShownMax) begin
          $display("mismatch: expected byte %02h term %0b last %0b, got byte %02h term %0b last %0b",
                   want.data, want.term, want.last, got.data, got.term, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = CapReset;
      clear_name();
      utf8_expect_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        compare_byte({rsp_i.out_byte, rsp_i.is_terminator, rsp_i.last});
      end
      if (req_i.valid && req_i.ready) begin
        transcode_unit(req_i.code_unit, req_i.first_unit);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CapAddr) begin
        capacity_q = pwdata_i[7:0];
      end
      fail_count_o <= mismatches;
      pending_o <= utf8_expect_q.size();
    end
  end

endmodule

// ----- tb/utf16le_to_utf8_name_transcoder_core_tb.sv -----
// Stimulus and verdict for the UTF-16LE to UTF-8 name transcoder.
`timescale 1ns / 1ps
module utf16le_to_utf8_name_transcoder_core_tb;
  import utf16u8_pkg::*;

  localparam int unsigned MaxUnits     = 36;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongStall    = 300;
  localparam int unsigned PhaseItems   = 90;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [PaddrW-1:0] CapAddr = PaddrW'(4 * RegOutCap);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          stall_go = 1'b0;
  bit          stall_taken = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  utf16u8_in_if  req_if ();
  utf16u8_out_if rsp_if ();

  initial begin
    req_if.valid      = 1'b0;
    req_if.code_unit  = '0;
    req_if.first_unit = 1'b0;
    rsp_if.ready      = 1'b0;
  end

  always #5 clk = ~clk;

  utf16le_to_utf8_name_transcoder_core #(
    .MAX_UNITS (MaxUnits)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  utf16u8_checker #(
    .MAX_UNITS (MaxUnits)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (stall_go && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left = LongStall;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_unit(input logic [15:0] unit, input logic first);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.code_unit  <= unit;
    req_if.first_unit <= first;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapAddr;
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_capacity();
    logic [7:0] cap;
    case ($urandom_range(0, 3))
      0:       cap = 8'd1;
      1:       cap = 8'd255;
      2:       cap = 8'($urandom_range(2, 12));
      default: cap = 8'($urandom_range(1, 255));
    endcase
    return cap;
  endfunction

  task automatic send_random_name(input bit force_long);
    logic [15:0] units[$];
    logic [15:0] w;
    logic        first;
    int unsigned len;
    int unsigned n;
    if ($urandom_range(0, 99) < 80) begin
      if (force_long || $urandom_range(0, 5) == 0) begin
        len = $urandom_range(30, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      while (units.size() < len) begin
        if (units.size() == MaxUnits - 1 && $urandom_range(0, 2) == 0) begin
          units.push_back(HighFirst + 16'($urandom_range(0, 1023)));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: units.push_back(16'($urandom_range(1, 16'h007F)));
            4: units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
            5: begin
              if ($urandom_range(0, 1) == 0) begin
                w = 16'($urandom_range(16'h0800, 16'hD7FF));
              end else begin
                w = 16'($urandom_range(16'hE000, 16'hFFFF));
              end
              units.push_back(w);
            end
            6, 7: begin
              units.push_back(HighFirst + 16'($urandom_range(0, 1023)));
              units.push_back(LowFirst + 16'($urandom_range(0, 1023)));
            end
            8: units.push_back(LowFirst + 16'($urandom_range(0, 1023)));
            default: begin
              units.push_back(HighFirst + 16'($urandom_range(0, 1023)));
              units.push_back(16'($urandom_range(1, 16'hD7FF)));
            end
          endcase
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        units.push_back(16'h0000);
      end
      foreach (units[i]) begin
        if (i > 0 && $urandom_range(0, 39) == 0) begin
          wait_idle();
          write_capacity(pick_capacity());
        end
        send_unit(units[i], i == 0);
      end
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < int'(n); i++) begin
        w = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
        first = ($urandom_range(0, 2) == 0);
        send_unit(w, first);
      end
    end
  endtask

  initial begin
    logic [15:0] directed_a [15];
    int unsigned target;
    directed_a = '{16'h0041, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
                   16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00,
                   16'hD834, 16'h0041, 16'hD800, 16'h0000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first name after reset starts without a first-unit mark.
    foreach (directed_a[i]) begin
      send_unit(directed_a[i], 1'b0);
    end
    send_unit(16'h0042, 1'b0);
    send_unit(16'hD800, 1'b1);
    send_unit(16'h0043, 1'b1);
    send_unit(16'h0000, 1'b0);

    // A tight buffer skips a long character but still takes a shorter one.
    wait_idle();
    write_capacity(8'd5);
    send_unit(16'h0800, 1'b1);
    send_unit(16'h0800, 1'b0);
    send_unit(16'h0041, 1'b0);
    wait_idle();
    write_capacity(8'd2);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0000, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 61;
          write_capacity(8'd255);
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 37;
          write_capacity(8'd1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_capacity(8'd72);
          stall_go = 1'b1;
          send_random_name(1'b1);
        end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          wait_idle();
          write_capacity(pick_capacity());
        end
        send_random_name(1'b0);
      end
    end

    wait_idle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
